// File: src/wstp_pkg.sv
`default_nettype none
package wstp_pkg;

    // weekdays and storage geometry
    localparam int DAYS         = 7;
    localparam int BANKS        = 2;
    localparam int ROWS         = BANKS * DAYS;
    localparam int ROW_W        = $clog2(ROWS);
    localparam int DAY_W        = 3;

    // default parameter values
    localparam int GROUP_DIGITS_DEF = 4;
    localparam int MAX_SLOTS_DEF    = 16;

    // field widths
    localparam int ACTION_W  = 2;
    localparam int CHAR_W    = 8;
    localparam int SLOT_IN_W = 4;
    localparam int STATUS_W  = 2;
    localparam int HOUR_W    = 16;
    localparam int LEN_OUT_W = 5;
    localparam int ACC_W     = 14;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 24;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // actions
    localparam logic [ACTION_W-1:0] ACT_FEED = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_END  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_BUSY = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERR  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SEPARATOR  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TERMINATOR = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_INVALID    = 2'd2;

    // configuration reset values
    localparam logic [CHAR_W-1:0] SEPARATOR_RST  = 8'd59;
    localparam logic [CHAR_W-1:0] TERMINATOR_RST = 8'd47;
    localparam logic [HOUR_W-1:0] INVALID_RST    = 16'hFFFF;

    // character constants
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SEVEN = 8'h37;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // parser phases
    localparam int PH_W = 2;
    localparam logic [PH_W-1:0] PH_START    = 2'd0;
    localparam logic [PH_W-1:0] PH_INSEG    = 2'd1;
    localparam logic [PH_W-1:0] PH_DONE_OK  = 2'd2;
    localparam logic [PH_W-1:0] PH_DONE_ERR = 2'd3;

endpackage
`default_nettype wire

// File: src/weekly_schedule_text_parser.sv
`default_nettype none
// Weekly schedule text parser. A schedule string is streamed in one character per
// transaction (tuser action 0); an end-of-string transaction (action 1) closes it and a read
// transaction (action 2) returns one stored hour slot of a weekday. Each segment is a weekday
// digit followed by groups of GROUP_DIGITS characters, one hour value per group; segments
// are split by the separator register and a terminator at segment start ends the string.
// Hour values live in a single-port-write, single-port-read synchronous memory of
// 2 x 7 x MAX_SLOTS words; a finished segment is committed by flipping that day's bank bit,
// so the live copy is never overwritten while a segment is being collected. Every
// transaction, of any kind, yields exactly one result transaction. The block accepts one
// transaction per cycle while the result stream is not stalled; a result passes through the
// registered memory read stage and then the output register. No clearing pass is needed after
// reset: a slot is only ever returned after it was written.
module weekly_schedule_text_parser
    import wstp_pkg::*;
#(
    parameter int GROUP_DIGITS = GROUP_DIGITS_DEF,
    parameter int MAX_SLOTS    = MAX_SLOTS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,  // char_byte[7:0], read_day[10:8], read_slot[14:11]
    input  wire logic [ACTION_W-1:0]   s_tuser,  // action[1:0]
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata,  // hour_value[15:0], day_length[20:16]
    output logic [STATUS_W-1:0]        m_tuser   // status[1:0]
);

    localparam int GW    = (GROUP_DIGITS > 1) ? $clog2(GROUP_DIGITS) : 1;
    localparam int LW    = $clog2(MAX_SLOTS + 1);
    localparam int SW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int DEPTH = ROWS * MAX_SLOTS;
    localparam int AW    = $clog2(DEPTH);

    // configuration registers
    logic [CHAR_W-1:0] separator_reg;
    logic [CHAR_W-1:0] terminator_reg;
    logic [HOUR_W-1:0] invalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            separator_reg  <= SEPARATOR_RST;
            terminator_reg <= TERMINATOR_RST;
            invalid_reg    <= INVALID_RST;
        end else if (cfg_wr_en) begin
            if (cfg_addr == CFG_SEPARATOR)  separator_reg  <= cfg_wr_data[CHAR_W-1:0];
            if (cfg_addr == CFG_TERMINATOR) terminator_reg <= cfg_wr_data[CHAR_W-1:0];
            if (cfg_addr == CFG_INVALID)    invalid_reg    <= cfg_wr_data;
        end
    end

    // input fields
    logic [ACTION_W-1:0]  action;
    logic [CHAR_W-1:0]    char_byte;
    logic [DAY_W-1:0]     read_day;
    logic [SLOT_IN_W-1:0] read_slot;
    logic                 accept;

    assign action    = s_tuser;
    assign char_byte = s_tdata[7:0];
    assign read_day  = s_tdata[10:8];
    assign read_slot = s_tdata[14:11];
    assign accept    = s_tvalid && s_tready;

    // parser state
    logic [PH_W-1:0]  phase_reg, phase_next;
    logic [DAYS-1:0]  bank_reg, bank_next;
    logic [DAYS-1:0]  seen_reg, seen_next;
    logic [DAY_W-1:0] day_reg, day_next;
    logic [GW-1:0]    gcc_reg, gcc_next;
    logic [LW-1:0]    gc_reg, gc_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             stopped_reg, stopped_next;
    logic [LW-1:0]    day_len_reg  [ROWS];
    logic [LW-1:0]    day_len_next [ROWS];

    // hour memory
    logic [HOUR_W-1:0] hour_mem [DEPTH];
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [ACC_W-1:0]  wr_value;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [HOUR_W-1:0] mem_q_reg;

    // per-character helpers
    logic             is_digit;
    logic             out_of_day;
    logic [ACC_W-1:0] acc_step;
    logic [GW:0]      gcc_inc;
    logic             group_full_cnt;
    logic             slots_full;
    logic             seg_good;
    logic             spare_bank;
    logic [ROW_W-1:0] spare_row;
    logic [ROW_W-1:0] live_row_rd;
    logic             rday_ok;
    logic [DAY_W-1:0] rday_idx;
    logic [LW-1:0]    rd_len;
    logic             rd_hit;
    logic [SW-1:0]    rd_slot;
    logic [STATUS_W-1:0] status_c;

    assign is_digit   = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
    assign out_of_day = (char_byte < CH_ZERO) || (char_byte >= CH_SEVEN);
    assign acc_step   = {acc_reg[ACC_W-4:0], 3'b000} + {acc_reg[ACC_W-2:0], 1'b0}
                      + ACC_W'(char_byte - CH_ZERO);
    assign gcc_inc        = {1'b0, gcc_reg} + (GW+1)'(1);
    assign group_full_cnt = (gcc_inc >= (GW+1)'(GROUP_DIGITS));
    assign slots_full     = (gc_reg >= LW'(MAX_SLOTS));
    assign seg_good       = (gcc_reg == '0) && (gc_reg != '0);
    assign spare_bank     = ~bank_reg[day_reg];
    assign spare_row      = spare_bank ? ROW_W'(day_reg) + ROW_W'(DAYS) : ROW_W'(day_reg);

    // read side lookup
    assign rday_ok     = (read_day < DAY_W'(DAYS));
    assign rday_idx    = rday_ok ? read_day : '0;
    assign live_row_rd = bank_reg[rday_idx] ? ROW_W'(rday_idx) + ROW_W'(DAYS)
                                            : ROW_W'(rday_idx);
    assign rd_len      = rday_ok ? day_len_reg[live_row_rd] : '0;
    assign rd_hit      = rday_ok && ({1'b0, read_slot} < LEN_OUT_W'(rd_len))
                      && ({1'b0, read_slot} < LEN_OUT_W'(MAX_SLOTS));
    assign rd_slot     = rd_hit ? read_slot[SW-1:0] : '0;
    assign rd_en       = accept && (action == ACT_READ) && rd_hit;
    assign rd_addr     = AW'(live_row_rd) * AW'(MAX_SLOTS) + AW'(rd_slot);
    assign wr_addr     = AW'(spare_row) * AW'(MAX_SLOTS) + AW'(gc_reg[SW-1:0]);

    // parser next state
    always_comb begin
        logic            commit;
        logic            fin_ok;
        logic            fin_err;
        logic [DAYS-1:0] bank_after;
        logic [DAYS-1:0] seen_after;
        phase_next   = phase_reg;
        bank_next    = bank_reg;
        seen_next    = seen_reg;
        day_next     = day_reg;
        gcc_next     = gcc_reg;
        gc_next      = gc_reg;
        acc_next     = acc_reg;
        stopped_next = stopped_reg;
        day_len_next = day_len_reg;
        wr_en        = 1'b0;
        wr_value     = acc_reg;
        status_c     = ST_BUSY;
        commit       = 1'b0;
        fin_ok       = 1'b0;
        fin_err      = 1'b0;

        if (accept && action == ACT_FEED) begin
            unique case (phase_reg)
                PH_START: begin
                    if (char_byte == terminator_reg) begin
                        fin_ok = 1'b1;
                    end else if (out_of_day) begin
                        fin_err = 1'b1;
                    end else begin
                        day_next     = char_byte[DAY_W-1:0];
                        gcc_next     = '0;
                        gc_next      = '0;
                        acc_next     = '0;
                        stopped_next = 1'b0;
                        phase_next   = PH_INSEG;
                    end
                end
                PH_INSEG: begin
                    if (char_byte == separator_reg) begin
                        if (seg_good) begin
                            commit     = 1'b1;
                            phase_next = PH_START;
                        end else begin
                            fin_err = 1'b1;
                        end
                    end else if (gcc_reg == '0 && slots_full) begin
                        fin_err = 1'b1;
                    end else begin
                        // accumulate digits until the first non-digit of the group
                        if (!stopped_reg && is_digit) begin
                            wr_value = acc_step;
                        end else begin
                            wr_value     = acc_reg;
                            stopped_next = 1'b1;
                        end
                        acc_next = wr_value;
                        gcc_next = gcc_inc[GW-1:0];
                        if (group_full_cnt) begin
                            wr_en        = 1'b1;
                            gc_next      = gc_reg + LW'(1);
                            gcc_next     = '0;
                            acc_next     = '0;
                            stopped_next = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (accept && action == ACT_END) begin
            unique case (phase_reg)
                PH_INSEG: begin
                    if (seg_good) begin
                        commit = 1'b1;
                        fin_ok = 1'b1;
                    end else begin
                        fin_err = 1'b1;
                    end
                end
                PH_START:   fin_ok = 1'b1;
                PH_DONE_OK: status_c = ST_OK;
                default:    status_c = ST_ERR;
            endcase
        end

        // segment commit by bank flip
        bank_after = bank_reg;
        seen_after = seen_reg;
        if (commit) begin
            day_len_next[spare_row] = gc_reg;
            bank_after[day_reg]     = ~bank_reg[day_reg];
            seen_after[day_reg]     = 1'b1;
        end
        bank_next = bank_after;
        seen_next = seen_after;

        // successful end clears the days not seen
        if (fin_ok) begin
            for (int d = 0; d < DAYS; d++) begin
                if (!seen_after[d]) begin
                    if (bank_after[d]) day_len_next[d + DAYS] = '0;
                    else               day_len_next[d] = '0;
                end
            end
            seen_next  = '0;
            phase_next = PH_DONE_OK;
            status_c   = ST_OK;
        end
        if (fin_err) begin
            seen_next  = '0;
            phase_next = PH_DONE_ERR;
            status_c   = ST_ERR;
        end

        // end of string readies a new string
        if (accept && action == ACT_END) begin
            phase_next = PH_START;
            seen_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_START;
            bank_reg    <= '0;
            seen_reg    <= '0;
            day_reg     <= '0;
            gcc_reg     <= '0;
            gc_reg      <= '0;
            acc_reg     <= '0;
            stopped_reg <= 1'b0;
            for (int r = 0; r < ROWS; r++) day_len_reg[r] <= '0;
        end else begin
            phase_reg   <= phase_next;
            bank_reg    <= bank_next;
            seen_reg    <= seen_next;
            day_reg     <= day_next;
            gcc_reg     <= gcc_next;
            gc_reg      <= gc_next;
            acc_reg     <= acc_next;
            stopped_reg <= stopped_next;
            day_len_reg <= day_len_next;
        end
    end

    // hour memory ports
    always_ff @(posedge aclk) begin
        if (wr_en) hour_mem[wr_addr] <= HOUR_W'(wr_value);
    end

    always_ff @(posedge aclk) begin
        if (rd_en) mem_q_reg <= hour_mem[rd_addr];
    end

    // result pipeline: memory read stage, then output register
    logic                 p1_valid_reg, p1_valid_next;
    logic [STATUS_W-1:0]  p1_status_reg;
    logic [HOUR_W-1:0]    p1_hour_reg;
    logic [LEN_OUT_W-1:0] p1_len_reg;
    logic                 p1_use_mem_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]  m_data_reg;
    logic [STATUS_W-1:0]  m_user_reg;
    logic                 out_ready;
    logic                 p1_adv;
    logic [HOUR_W-1:0]    p1_hour_sel;

    assign out_ready   = !m_valid_reg || m_tready;
    assign p1_adv      = p1_valid_reg && out_ready;
    assign s_tready    = !p1_valid_reg || out_ready;
    assign p1_hour_sel = p1_use_mem_reg ? mem_q_reg : p1_hour_reg;

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (accept)      p1_valid_next = 1'b1;
        else if (p1_adv) p1_valid_next = 1'b0;
        m_valid_next = m_valid_reg;
        if (p1_adv)        m_valid_next = 1'b1;
        else if (m_tready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // capture result side info of the accepted transaction
    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_status_reg  <= status_c;
            p1_use_mem_reg <= rd_en;
            if (action == ACT_READ) begin
                p1_hour_reg <= invalid_reg;
                p1_len_reg  <= LEN_OUT_W'(rd_len);
            end else begin
                p1_hour_reg <= '0;
                p1_len_reg  <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            m_data_reg <= {3'b000, p1_len_reg, p1_hour_sel};
            m_user_reg <= p1_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
`default_nettype wire
